[rtl/core/gbn_pkg.sv]
`default_nettype none
package gbn_pkg;

   localparam int SEQ_COUNT   = 20;
   localparam int MAX_PACKETS = 128;

   localparam int SEQ_W  = 5;
   localparam int IDX_W  = 7;
   localparam int CNT_W  = 8;
   localparam int WIN_W  = 5;
   localparam int OP_W   = 2;
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam logic [SEQ_W-1:0] SEQ_LAST  = SEQ_W'(SEQ_COUNT - 1);
   localparam logic [SEQ_W-1:0] SEQ_TOP   = SEQ_W'(SEQ_COUNT);
   localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(SEQ_COUNT - 1);
   localparam logic [CNT_W-1:0] TOTAL_MAX = CNT_W'(MAX_PACKETS);

   localparam logic [CNT_W-1:0] PACKET_TOTAL_RST  = 8'd0;
   localparam logic [WIN_W-1:0] WINDOW_SIZE_RST   = 5'd10;
   localparam logic [CNT_W-1:0] TIMEOUT_POLLS_RST = 8'd20;

   typedef enum logic [OP_W-1:0] {
      OP_START    = 2'd0,
      OP_POLL     = 2'd1,
      OP_POLL_ACK = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_PACKET_TOTAL  = 2'd0,
      REG_WINDOW_SIZE   = 2'd1,
      REG_TIMEOUT_POLLS = 2'd2,
      REG_UNUSED        = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [CNT_W-1:0] packet_total;
      logic [WIN_W-1:0] window_size;
      logic [CNT_W-1:0] timeout_polls;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [SEQ_W-1:0] ack_seq;
      logic             ack_done;
   } req_item_type;

   typedef struct packed {
      logic             send_valid;
      logic [SEQ_W-1:0] send_seq;
      logic [IDX_W-1:0] send_index;
      logic             send_last;
      logic             timeout_fired;
      logic             done_res;
   } rsp_item_type;

   // modular distance a - b over the sequence space
   function automatic logic [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] a,
                                                 input logic [SEQ_W-1:0] b);
      logic [SEQ_W:0] s;
      s = {1'b0, a} + (SEQ_W+1)'(SEQ_COUNT) - {1'b0, b};
      if (s >= (SEQ_W+1)'(SEQ_COUNT)) begin
         s = s - (SEQ_W+1)'(SEQ_COUNT);
      end
      return s[SEQ_W-1:0];
   endfunction

endpackage
`default_nettype wire

[rtl/core/gbn_ifs.sv]
`default_nettype none
interface gbn_req_if;
   logic                       valid;
   logic                       ready;
   logic [gbn_pkg::OP_W-1:0]   op;
   logic [gbn_pkg::SEQ_W-1:0]  ack_seq;
   logic                       ack_done;

   modport source (output valid, op, ack_seq, ack_done, input ready);
   modport sink   (input valid, op, ack_seq, ack_done, output ready);
endinterface

interface gbn_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       send_valid;
   logic [gbn_pkg::SEQ_W-1:0]  send_seq;
   logic [gbn_pkg::IDX_W-1:0]  send_index;
   logic                       send_last;
   logic                       timeout_fired;
   logic                       done_res;

   modport source (output valid, send_valid, send_seq, send_index, send_last,
                   timeout_fired, done_res, input ready);
   modport sink   (input valid, send_valid, send_seq, send_index, send_last,
                   timeout_fired, done_res, output ready);
endinterface
`default_nettype wire

[rtl/core/go_back_n_sender_window.sv]
// datapath: an accepted item is held in the input register, and its result is
// registered in the result register when that register is empty or being taken
// throughput: one item per cycle while rsp_ch.ready is not held low; a full
// result register stalls the window update between the two registers
// reset: synchronous, active high; clears the window state and both stages,
// and loads the registers with packet_total 0, window_size 10, timeout_polls 20
`default_nettype none
module go_back_n_sender_window (
   input  wire logic                        clock,
   input  wire logic                        reset,
   gbn_req_if.sink                          req_ch,
   gbn_rsp_if.source                        rsp_ch,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [gbn_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [gbn_pkg::DATA_W-1:0]  csr_pwdata,
   output      logic [gbn_pkg::DATA_W-1:0]  csr_prdata,
   output      logic                        csr_pready
);
   import gbn_pkg::*;

   cfg_type      cfg;
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type step_result;
   logic         advance;
   logic         take;

   gbn_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   gbn_window u_window (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .item    (in_item_ff),
      .result  (step_result)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;
   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff.op       <= req_ch.op;
         in_item_ff.ack_seq  <= req_ch.ack_seq;
         in_item_ff.ack_done <= req_ch.ack_done;
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.send_valid    = out_item_ff.send_valid;
   assign rsp_ch.send_seq      = out_item_ff.send_seq;
   assign rsp_ch.send_index    = out_item_ff.send_index;
   assign rsp_ch.send_last     = out_item_ff.send_last;
   assign rsp_ch.timeout_fired = out_item_ff.timeout_fired;
   assign rsp_ch.done_res      = out_item_ff.done_res;

`ifndef NO_ASSERTIONS
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_item_ff.send_valid |->
         out_item_ff.send_seq == '0 && out_item_ff.send_index == '0 &&
         !out_item_ff.send_last)
      else $error("send fields set without a send");
   a_fire_not_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.timeout_fired |-> !out_item_ff.done_res)
      else $error("rewind reported on a finished session");
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register lost an item");
`endif

endmodule
`default_nettype wire

[rtl/core/gbn_csr.sv]
`default_nettype none
module gbn_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [gbn_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [gbn_pkg::DATA_W-1:0]  pwdata,
   output      logic [gbn_pkg::DATA_W-1:0]  prdata,
   output      logic                        pready,
   output      gbn_pkg::cfg_type            cfg
);
   import gbn_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign reg_idx = reg_idx_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_PACKET_TOTAL:  cfg_in.packet_total  = pwdata[CNT_W-1:0];
            REG_WINDOW_SIZE:   cfg_in.window_size   = pwdata[WIN_W-1:0];
            REG_TIMEOUT_POLLS: cfg_in.timeout_polls = pwdata[CNT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_PACKET_TOTAL:  prdata = DATA_W'(cfg_ff.packet_total);
         REG_WINDOW_SIZE:   prdata = DATA_W'(cfg_ff.window_size);
         REG_TIMEOUT_POLLS: prdata = DATA_W'(cfg_ff.timeout_polls);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.packet_total  <= PACKET_TOTAL_RST;
         cfg_ff.window_size   <= WINDOW_SIZE_RST;
         cfg_ff.timeout_polls <= TIMEOUT_POLLS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/gbn_window.sv]
`default_nettype none
module gbn_window (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gbn_pkg::cfg_type      cfg,
   input  wire logic                  step_en,
   input  wire gbn_pkg::req_item_type item,
   output      gbn_pkg::rsp_item_type result
);
   import gbn_pkg::*;

   logic [SEQ_W-1:0] next_seq_ff, next_seq_in;
   logic [SEQ_W-1:0] base_seq_ff, base_seq_in;
   logic [CNT_W-1:0] sent_count_ff, sent_count_in;
   logic [CNT_W-1:0] wait_count_ff, wait_count_in;
   logic             finished_ff, finished_in;

   op_type           op;
   logic [WIN_W-1:0] win_eff;
   logic [CNT_W-1:0] total_eff;
   logic [SEQ_W-1:0] dist0;
   logic             can_send;
   logic [SEQ_W-1:0] next_inc;
   logic [SEQ_W-1:0] outstanding;
   logic [CNT_W-1:0] sent_after;
   logic [CNT_W:0]   wait_inc;
   logic [SEQ_W-1:0] ack_idx;
   logic             ack_in_range;

   assign op        = op_type'(item.op);
   assign win_eff   = (cfg.window_size > WIN_MAX) ? WIN_MAX : cfg.window_size;
   assign total_eff = (cfg.packet_total > TOTAL_MAX) ? TOTAL_MAX : cfg.packet_total;
   assign dist0     = seq_dist(next_seq_ff, base_seq_ff);
   assign can_send  = (WIN_W'(dist0) < win_eff) && (sent_count_ff < total_eff);
   assign next_inc  = (next_seq_ff == SEQ_LAST) ? '0 : next_seq_ff + 1'b1;
   assign outstanding = dist0 + SEQ_W'(can_send);
   assign sent_after  = sent_count_ff + CNT_W'(can_send);
   assign wait_inc    = {1'b0, wait_count_ff} + 1'b1;
   assign ack_idx     = item.ack_seq - 1'b1;
   assign ack_in_range = (item.ack_seq != '0) && (item.ack_seq <= SEQ_TOP) &&
                         (seq_dist(ack_idx, base_seq_ff) < outstanding);

   always_comb begin
      next_seq_in   = next_seq_ff;
      base_seq_in   = base_seq_ff;
      sent_count_in = sent_count_ff;
      wait_count_in = wait_count_ff;
      finished_in   = finished_ff;
      result        = '0;
      if (op == OP_START) begin
         next_seq_in   = '0;
         base_seq_in   = '0;
         sent_count_in = '0;
         wait_count_in = '0;
         finished_in   = 1'b0;
      end else if (op != OP_NONE && !finished_ff) begin
         if (can_send) begin
            result.send_valid = 1'b1;
            result.send_seq   = next_seq_ff + 1'b1;
            result.send_index = sent_count_ff[IDX_W-1:0];
            result.send_last  = ({1'b0, sent_count_ff} + 1'b1) == {1'b0, total_eff};
            next_seq_in       = next_inc;
         end
         sent_count_in = sent_after;
         if (op == OP_POLL) begin
            if (wait_inc > {1'b0, cfg.timeout_polls}) begin
               sent_count_in = (sent_after >= CNT_W'(outstanding)) ?
                               sent_after - CNT_W'(outstanding) : '0;
               next_seq_in   = base_seq_ff;
               wait_count_in = '0;
               result.timeout_fired = 1'b1;
            end else begin
               wait_count_in = wait_inc[CNT_W-1:0];
            end
         end else begin
            if (item.ack_done) begin
               finished_in = 1'b1;
            end else if (ack_in_range) begin
               base_seq_in = (item.ack_seq == SEQ_TOP) ? '0 : item.ack_seq;
            end
            wait_count_in = '0;
         end
      end
      result.done_res = finished_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_seq_ff   <= '0;
         base_seq_ff   <= '0;
         sent_count_ff <= '0;
         wait_count_ff <= '0;
         finished_ff   <= 1'b0;
      end else if (step_en) begin
         next_seq_ff   <= next_seq_in;
         base_seq_ff   <= base_seq_in;
         sent_count_ff <= sent_count_in;
         wait_count_ff <= wait_count_in;
         finished_ff   <= finished_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_next_range: assert property (@(posedge clock) disable iff (reset)
      next_seq_ff <= SEQ_LAST)
      else $error("next_seq out of range");
   a_base_range: assert property (@(posedge clock) disable iff (reset)
      base_seq_ff <= SEQ_LAST)
      else $error("base_seq out of range");
   a_outstanding: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(seq_dist(next_seq_ff, base_seq_ff)) <= sent_count_ff)
      else $error("more outstanding than sent");
   a_finished_quiet: assert property (@(posedge clock) disable iff (reset)
      step_en && finished_ff && op != OP_START |=>
         $stable(next_seq_ff) && $stable(base_seq_ff) && finished_ff)
      else $error("state moved after finish");
`endif

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import gbn_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASES = 9;
   localparam int PHASE_ITEMS = 90;

   typedef struct packed {
      logic         is_cfg;
      reg_idx_type  reg_sel;
      logic [31:0]  wdata;
      req_item_type it;
      logic         typed;
      rsp_item_type want;
   } script_row_type;

   localparam rsp_item_type IDLE_RSP = '0;
   localparam rsp_item_type DONE_RSP = '{send_valid: 1'b0, send_seq: '0, send_index: '0,
                                         send_last: 1'b0, timeout_fired: 1'b0,
                                         done_res: 1'b1};

   logic clock = 1'b0;
   logic reset;
   logic calm;

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   gbn_req_if req_ch ();
   gbn_rsp_if rsp_ch ();

   go_back_n_sender_window dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // sender window as the block should hold it
   int cfg_total;
   int cfg_window;
   int cfg_timeout;
   int win_next;
   int win_base;
   int pkts_sent;
   int idle_polls;
   bit xfer_done;

   rsp_item_type poll_outcomes[$];
   int mismatch_count = 0;
   int cycle_count = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int ring_gap(input int a, input int b);
      return (a + SEQ_COUNT - b) % SEQ_COUNT;
   endfunction

   function automatic rsp_item_type advance_window(input req_item_type it);
      rsp_item_type r;
      int total;
      int win;
      int outst;
      int ack;
      r = '0;
      if (it.op == OP_START) begin
         win_next = 0;
         win_base = 0;
         pkts_sent = 0;
         idle_polls = 0;
         xfer_done = 1'b0;
      end else if (it.op != OP_NONE && !xfer_done) begin
         total = (cfg_total > MAX_PACKETS) ? MAX_PACKETS : cfg_total;
         win = (cfg_window > SEQ_COUNT - 1) ? SEQ_COUNT - 1 : cfg_window;
         if (ring_gap(win_next, win_base) < win && pkts_sent < total) begin
            r.send_valid = 1'b1;
            r.send_seq = SEQ_W'(win_next + 1);
            r.send_index = IDX_W'(pkts_sent);
            r.send_last = (pkts_sent + 1 == total);
            win_next = (win_next + 1) % SEQ_COUNT;
            pkts_sent = (pkts_sent + 1) & 8'hFF;
         end
         outst = ring_gap(win_next, win_base);
         if (it.op == OP_POLL) begin
            if (idle_polls + 1 > cfg_timeout) begin
               pkts_sent = (pkts_sent >= outst) ? pkts_sent - outst : 0;
               win_next = win_base;
               idle_polls = 0;
               r.timeout_fired = 1'b1;
            end else begin
               idle_polls = (idle_polls + 1) & 8'hFF;
            end
         end else begin
            ack = int'(it.ack_seq);
            if (it.ack_done) begin
               xfer_done = 1'b1;
            end else if (ack >= 1 && ack <= SEQ_COUNT) begin
               if (ring_gap(ack - 1, win_base) < outst) begin
                  win_base = ack % SEQ_COUNT;
               end
            end
            idle_polls = 0;
         end
      end
      r.done_res = xfer_done;
      return r;
   endfunction

   function automatic script_row_type cfg_row(input reg_idx_type sel, input int value);
      script_row_type row;
      row = '0;
      row.is_cfg = 1'b1;
      row.reg_sel = sel;
      row.wdata = 32'(value);
      return row;
   endfunction

   function automatic script_row_type poll_row(input op_type op, input int ack, input bit done);
      script_row_type row;
      row = '0;
      row.it.op = op;
      row.it.ack_seq = SEQ_W'(ack);
      row.it.ack_done = done;
      return row;
   endfunction

   function automatic script_row_type fixed_row(input op_type op, input int ack,
                                                input bit done, input rsp_item_type want);
      script_row_type row;
      row = poll_row(op, ack, done);
      row.typed = 1'b1;
      row.want = want;
      return row;
   endfunction

   task automatic flag_mismatch(input string field, input logic [7:0] got,
                                input logic [7:0] want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, field, got, want);
      mismatch_count++;
   endtask

   task automatic push_item(input req_item_type it, input bit typed, input rsp_item_type want);
      rsp_item_type predicted;
      while (!calm && $urandom_range(0, 99) < 16) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= it.op;
      req_ch.ack_seq <= it.ack_seq;
      req_ch.ack_done <= it.ack_done;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = advance_window(it);
      poll_outcomes.push_back(typed ? want : predicted);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (poll_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_idx_type sel, input logic [31:0] data);
      logic [31:0] keep;
      keep = (sel == REG_WINDOW_SIZE) ? 32'h1F : 32'hFF;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_W'(int'(sel) * 4);
      csr_pwdata <= (data & keep) | ($urandom & ~keep);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (sel)
         REG_PACKET_TOTAL: cfg_total = int'(data & keep);
         REG_WINDOW_SIZE: cfg_window = int'(data & keep);
         REG_TIMEOUT_POLLS: cfg_timeout = int'(data & keep);
         default: ;
      endcase
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
   end

   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (poll_outcomes.size() == 0) begin
            flag_mismatch("unexpected item", 8'd1, 8'd0);
         end else begin
            want = poll_outcomes.pop_front();
            if (rsp_ch.send_valid !== want.send_valid)
               flag_mismatch("send_valid", 8'(rsp_ch.send_valid), 8'(want.send_valid));
            if (rsp_ch.send_seq !== want.send_seq)
               flag_mismatch("send_seq", 8'(rsp_ch.send_seq), 8'(want.send_seq));
            if (rsp_ch.send_index !== want.send_index)
               flag_mismatch("send_index", 8'(rsp_ch.send_index), 8'(want.send_index));
            if (rsp_ch.send_last !== want.send_last)
               flag_mismatch("send_last", 8'(rsp_ch.send_last), 8'(want.send_last));
            if (rsp_ch.timeout_fired !== want.timeout_fired)
               flag_mismatch("timeout_fired", 8'(rsp_ch.timeout_fired),
                             8'(want.timeout_fired));
            if (rsp_ch.done_res !== want.done_res)
               flag_mismatch("done_res", 8'(rsp_ch.done_res), 8'(want.done_res));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      script_row_type plan[$];
      req_item_type it;
      int total_edge[4];
      int window_edge[4];
      int timeout_edge[4];
      int phase;
      int n;
      int roll;
      int gap;
      int total;
      total_edge = '{1, 255, 128, 40};
      window_edge = '{1, 31, 19, 5};
      timeout_edge = '{0, 255, 1, 3};

      reset <= 1'b1;
      calm <= 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.op <= OP_NONE;
      req_ch.ack_seq <= '0;
      req_ch.ack_done <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;

      cfg_total = int'(PACKET_TOTAL_RST);
      cfg_window = int'(WINDOW_SIZE_RST);
      cfg_timeout = int'(TIMEOUT_POLLS_RST);
      win_next = 0;
      win_base = 0;
      pkts_sent = 0;
      idle_polls = 0;
      xfer_done = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      plan = '{
         fixed_row(OP_POLL, 0, 1'b0, IDLE_RSP),
         fixed_row(OP_NONE, 31, 1'b1, IDLE_RSP),
         cfg_row(REG_PACKET_TOTAL, 3),
         cfg_row(REG_WINDOW_SIZE, 2),
         cfg_row(REG_TIMEOUT_POLLS, 1),
         fixed_row(OP_START, 0, 1'b0, IDLE_RSP),
         poll_row(OP_POLL, 5, 1'b0),
         poll_row(OP_POLL, 0, 1'b0),
         poll_row(OP_POLL_ACK, 1, 1'b0),
         poll_row(OP_POLL_ACK, 0, 1'b0),
         poll_row(OP_POLL_ACK, 31, 1'b0),
         poll_row(OP_POLL_ACK, 10, 1'b0),
         poll_row(OP_POLL_ACK, 3, 1'b0),
         fixed_row(OP_POLL_ACK, 0, 1'b1, DONE_RSP),
         fixed_row(OP_POLL, 0, 1'b0, DONE_RSP),
         cfg_row(REG_WINDOW_SIZE, 0),
         fixed_row(OP_START, 0, 1'b0, IDLE_RSP),
         fixed_row(OP_POLL, 0, 1'b0, IDLE_RSP),
         cfg_row(REG_PACKET_TOTAL, 255),
         cfg_row(REG_WINDOW_SIZE, 31),
         cfg_row(REG_TIMEOUT_POLLS, 0),
         poll_row(OP_START, 0, 1'b0),
         poll_row(OP_POLL, 0, 1'b0),
         poll_row(OP_POLL_ACK, 20, 1'b0),
         poll_row(OP_POLL_ACK, 1, 1'b0),
         cfg_row(REG_PACKET_TOTAL, 128),
         cfg_row(REG_WINDOW_SIZE, 19),
         cfg_row(REG_TIMEOUT_POLLS, 255),
         poll_row(OP_START, 0, 1'b0),
         poll_row(OP_POLL_ACK, 21, 1'b0),
         poll_row(OP_POLL, 0, 1'b0)
      };
      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            drain_results();
            write_reg(plan[i].reg_sel, plan[i].wdata);
         end else begin
            push_item(plan[i].it, plan[i].typed, plan[i].want);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         calm <= (phase == 4);
         drain_results();
         if (phase < 4) begin
            write_reg(REG_PACKET_TOTAL, 32'(total_edge[phase]));
            write_reg(REG_WINDOW_SIZE, 32'(window_edge[phase]));
            write_reg(REG_TIMEOUT_POLLS, 32'(timeout_edge[phase]));
         end else begin
            write_reg(REG_PACKET_TOTAL, 32'($urandom_range(1, 60)));
            write_reg(REG_WINDOW_SIZE, 32'($urandom_range(0, 31)));
            write_reg(REG_TIMEOUT_POLLS, ($urandom_range(0, 3) == 0) ?
                      32'($urandom_range(0, 255)) : 32'($urandom_range(0, 8)));
         end
         it.op = OP_START;
         it.ack_seq = '0;
         it.ack_done = 1'b0;
         push_item(it, 1'b0, IDLE_RSP);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 2 && n == PHASE_ITEMS / 2) drain_results();
            roll = $urandom_range(0, 99);
            it.op = OP_NONE;
            it.ack_seq = SEQ_W'($urandom_range(0, 31));
            it.ack_done = ($urandom_range(0, 7) == 0);
            if (roll < 3 || (xfer_done && roll < 40)) begin
               it.op = OP_START;
            end else if (roll < 6) begin
               it.op = OP_NONE;
            end else if (roll < 30) begin
               it.op = OP_POLL;
            end else begin
               it.op = OP_POLL_ACK;
               if (roll >= 45) begin
                  // well-formed ack, inside the outstanding range when any packet is outstanding
                  gap = ring_gap(win_next, win_base);
                  total = (cfg_total > MAX_PACKETS) ? MAX_PACKETS : cfg_total;
                  if (gap > 0)
                     it.ack_seq = SEQ_W'((win_base + $urandom_range(0, gap - 1)) % SEQ_COUNT + 1);
                  else
                     it.ack_seq = SEQ_W'($urandom_range(1, SEQ_COUNT));
                  it.ack_done = ($urandom_range(0, 99) < ((pkts_sent >= total) ? 8 : 1));
               end
            end
            push_item(it, 1'b0, IDLE_RSP);
         end
      end

      calm <= 1'b0;
      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
